@@ design/line_follower_grid_navigator_assert.svh @@
// ----------------------------------------------------------------------------
// Line follower grid navigator assertion macros
// Shared property shapes for the navigator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_GRID_NAVIGATOR_ASSERT_SVH
`define LINE_FOLLOWER_GRID_NAVIGATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LFGN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfgn: same-cycle check failed");

// next-cycle implication, disabled in reset
`define LFGN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfgn: next-cycle check failed");

`endif

@@ design/lfgn_pkg.sv @@
// ----------------------------------------------------------------------------
// Line follower grid navigator package
// Codes, configuration defaults and shared types of the navigator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfgn_pkg;

	localparam int GRID_COUNT_BITS_DEF = 16;
	localparam int CFG_INDEX_BITS      = 3;

	// motor actions
	localparam logic [1:0] MOTOR_REL = 2'd0;
	localparam logic [1:0] MOTOR_FWD = 2'd1;
	localparam logic [1:0] MOTOR_BAK = 2'd2;

	// maneuver codes
	localparam logic [2:0] MAN_FORWARD  = 3'd0;
	localparam logic [2:0] MAN_BACKWARD = 3'd1;
	localparam logic [2:0] MAN_RIGHT    = 3'd2;
	localparam logic [2:0] MAN_LEFT     = 3'd3;
	localparam logic [2:0] MAN_AROUND   = 3'd4;

	// maneuver phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_BACKOFF = 3'd1;
	localparam logic [2:0] PH_SWEEP   = 3'd2;
	localparam logic [2:0] PH_FOLLOW  = 3'd3;
	localparam logic [2:0] PH_FINAL   = 3'd4;
	localparam logic [2:0] PH_SPIN    = 3'd5;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CRUISE_SPEED   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MANEUVER_SPEED = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SWEEP_LIMIT    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CONFIRM_LIMIT  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAVEL_LIMIT   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_LIMIT     = 3'd5;

	typedef struct packed {
		logic [7:0] cruise_speed;
		logic [7:0] maneuver_speed;
		logic [7:0] turn_sweep_limit;
		logic [7:0] mid_confirm_limit;
		logic [7:0] mid_travel_limit;
		logic [7:0] stop_line_limit;
	} lfgn_cfg_t;

	localparam lfgn_cfg_t CFG_RESET = '{
		cruise_speed:      8'd180,
		maneuver_speed:    8'd200,
		turn_sweep_limit:  8'd50,
		mid_confirm_limit: 8'd20,
		mid_travel_limit:  8'd150,
		stop_line_limit:   8'd10
	};

	typedef struct packed {
		logic [2:0] maneuver;
		logic [2:0] phase;
		logic [1:0] mid_stage;
		logic [7:0] phase_cnt;
		logic [7:0] sweep_cnt;
		logic [1:0] motor_one;
		logic [1:0] motor_two;
		logic [7:0] speed;
	} lfgn_state_t;

	localparam lfgn_state_t STATE_RESET = '{
		maneuver:  MAN_FORWARD,
		phase:     PH_IDLE,
		mid_stage: 2'd0,
		phase_cnt: 8'd0,
		sweep_cnt: 8'd0,
		motor_one: MOTOR_REL,
		motor_two: MOTOR_REL,
		speed:     8'd0
	};

	typedef struct packed {
		logic       command;
		logic [2:0] maneuver;
		logic       front_right;
		logic       front_left;
		logic       back_right;
		logic       back_left;
	} lfgn_sample_t;

endpackage

@@ design/lfgn_if.sv @@
// ----------------------------------------------------------------------------
// Line follower grid navigator channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfgn_cmd_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [2:0] maneuver;
	logic       front_right;
	logic       front_left;
	logic       back_right;
	logic       back_left;

	modport source (
		output valid, command, maneuver, front_right, front_left, back_right, back_left,
		input  ready
	);
	modport sink (
		input  valid, command, maneuver, front_right, front_left, back_right, back_left,
		output ready
	);
endinterface

interface lfgn_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] motor_one_action;
	logic [1:0] motor_two_action;
	logic [7:0] motor_speed;
	logic       maneuver_done;
	logic       busy_res;
	logic [15:0] grid_count;

	modport source (
		output valid, motor_one_action, motor_two_action, motor_speed, maneuver_done,
		       busy_res, grid_count,
		input  ready
	);
	modport sink (
		input  valid, motor_one_action, motor_two_action, motor_speed, maneuver_done,
		       busy_res, grid_count,
		output ready
	);
endinterface

@@ design/lfgn_step.sv @@
// ----------------------------------------------------------------------------
// Line follower grid navigator step logic
// Next motor commands, phase, counters and grid count for one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfgn_step #(
	parameter int GRID_COUNT_BITS = lfgn_pkg::GRID_COUNT_BITS_DEF
) (
	input  lfgn_pkg::lfgn_state_t       cur,
	input  logic [GRID_COUNT_BITS-1:0]  grids_cur,
	input  lfgn_pkg::lfgn_cfg_t         cfg,
	input  lfgn_pkg::lfgn_sample_t      smp,
	output lfgn_pkg::lfgn_state_t       nxt,
	output logic [GRID_COUNT_BITS-1:0]  grids_nxt,
	output logic                        done
);
	import lfgn_pkg::*;

	localparam logic [GRID_COUNT_BITS-1:0] GRID_ONE = GRID_COUNT_BITS'(1);

	// side steering by the single-sided sensors; keeps the motors when nothing matches
	function automatic logic [3:0] lateral(input logic fr, input logic fl, input logic br,
		input logic bl, input logic [1:0] d, input logic [3:0] cur_mot);
		logic [3:0] r;
		r = cur_mot;
		if (fr && br) r = {MOTOR_REL, d};
		else if (fl && bl) r = {d, MOTOR_REL};
		else if (bl) r = {MOTOR_BAK, MOTOR_FWD};
		else if (br) r = {MOTOR_FWD, MOTOR_BAK};
		else if (fr) r = {MOTOR_BAK, MOTOR_FWD};
		else if (fl) r = {MOTOR_FWD, MOTOR_BAK};
		return r;
	endfunction

	logic on_fr, on_fl, on_br, on_bl, all_off;
	logic turn, around, watch, do_sweep, stop;
	lfgn_state_t s;
	logic [GRID_COUNT_BITS-1:0] g;
	logic dn;

	// sensor level 0 means over the line
	assign on_fr   = ~smp.front_right;
	assign on_fl   = ~smp.front_left;
	assign on_br   = ~smp.back_right;
	assign on_bl   = ~smp.back_left;
	assign all_off = ~on_fr & ~on_fl & ~on_br & ~on_bl;
	assign turn    = (cur.maneuver != MAN_FORWARD);
	assign around  = (cur.maneuver == MAN_AROUND);

	always_comb begin
		s        = cur;
		g        = grids_cur;
		dn       = 1'b0;
		do_sweep = 1'b0;
		stop     = 1'b0;
		watch    = 1'b0;
		if (smp.command) begin
			if (smp.maneuver <= MAN_AROUND) begin
				s.maneuver  = smp.maneuver;
				s.speed     = (smp.maneuver == MAN_FORWARD) ? cfg.cruise_speed
				                                           : cfg.maneuver_speed;
				s.mid_stage = 2'd0;
				s.phase_cnt = 8'd0;
				s.sweep_cnt = 8'd0;
				if (smp.maneuver == MAN_FORWARD || smp.maneuver == MAN_BACKWARD)
					s.phase = PH_FOLLOW;
				else if (smp.maneuver == MAN_AROUND)
					s.phase = PH_SPIN;
				else
					s.phase = PH_BACKOFF;
			end
		end else begin
			case (cur.phase)
				PH_BACKOFF: begin
					if ((cur.maneuver == MAN_RIGHT) ? on_fr : on_fl) begin
						if (cur.maneuver == MAN_RIGHT) s.motor_one = MOTOR_BAK;
						else s.motor_two = MOTOR_BAK;
					end else begin
						// leave the line: swing the outer motor, this beat also sweeps
						s.motor_one = MOTOR_REL;
						s.motor_two = MOTOR_REL;
						if (cur.maneuver == MAN_RIGHT) s.motor_two = MOTOR_FWD;
						else s.motor_one = MOTOR_FWD;
						s.phase  = PH_SWEEP;
						do_sweep = 1'b1;
					end
				end
				PH_SWEEP: begin
					do_sweep = 1'b1;
				end
				PH_FOLLOW: begin
					if (cur.maneuver == MAN_BACKWARD || around) begin
						if (all_off || (on_bl && on_br) || (on_fr && on_fl && s.mid_stage == 2'd0))
							{s.motor_one, s.motor_two} = {MOTOR_BAK, MOTOR_BAK};
						else
							{s.motor_one, s.motor_two} = lateral(on_fr, on_fl, on_br, on_bl,
								MOTOR_BAK, {s.motor_one, s.motor_two});
						if (!on_bl && !on_br) {s.motor_one, s.motor_two} = {MOTOR_BAK, MOTOR_BAK};
						if (!on_fl && !on_fr) {s.motor_one, s.motor_two} = {MOTOR_BAK, MOTOR_BAK};
						if (on_br && on_bl && s.mid_stage == 2'd0) begin
							{s.motor_one, s.motor_two} = {MOTOR_BAK, MOTOR_BAK};
							s.mid_stage = 2'd1;
						end
						if ((!on_fr || !on_fl) && s.mid_stage == 2'd2)
							s.phase_cnt = s.phase_cnt + 8'd1;
						if (!around && s.mid_stage == 2'd2
						    && s.phase_cnt == cfg.mid_travel_limit) begin
							{s.motor_one, s.motor_two} = {MOTOR_REL, MOTOR_REL};
							s.mid_stage = 2'd3;
							s.phase_cnt = 8'd0;
							s.phase     = PH_FINAL;
							stop        = 1'b1;
						end
						if (!stop) begin
							if (on_fr && on_fl && s.mid_stage == 2'd1) begin
								{s.motor_one, s.motor_two} = {MOTOR_BAK, MOTOR_BAK};
								s.phase_cnt = s.phase_cnt + 8'd1;
							end
							if (s.mid_stage == 2'd1 && s.phase_cnt == cfg.mid_confirm_limit) begin
								s.mid_stage = 2'd2;
								s.phase_cnt = 8'd0;
							end
							if (around && s.mid_stage == 2'd2
							    && s.phase_cnt == cfg.mid_travel_limit) begin
								{s.motor_one, s.motor_two} = {MOTOR_REL, MOTOR_REL};
								s.mid_stage = 2'd3;
								s.phase_cnt = 8'd0;
								s.phase     = PH_FINAL;
							end
						end
					end else begin
						if (all_off || (on_bl && on_br))
							{s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_FWD};
						else if (on_fr && on_fl && (turn || s.mid_stage == 2'd1)) begin
							// front pair on the line: maneuver complete
							{s.motor_one, s.motor_two} = {MOTOR_REL, MOTOR_REL};
							g       = g + GRID_ONE;
							s.phase = PH_IDLE;
							dn      = 1'b1;
							stop    = 1'b1;
						end else if (on_fr && on_fl && s.mid_stage == 2'd0)
							{s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_FWD};
						else
							{s.motor_one, s.motor_two} = lateral(on_fr, on_fl, on_br, on_bl,
								MOTOR_FWD, {s.motor_one, s.motor_two});
						if (!stop) begin
							if (!on_bl && !on_br) {s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_FWD};
							if (!on_fl && !on_fr) {s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_FWD};
							if (!turn && on_br && on_bl && s.mid_stage == 2'd0) s.mid_stage = 2'd1;
						end
					end
				end
				PH_FINAL: begin
					if (all_off || (on_bl && on_br))
						{s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_FWD};
					else if (on_fr && on_fl)
						s.phase_cnt = s.phase_cnt + 8'd1;
					else
						{s.motor_one, s.motor_two} = lateral(on_fr, on_fl, on_br, on_bl,
							MOTOR_FWD, {s.motor_one, s.motor_two});
					if (!on_bl && !on_br) {s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_FWD};
					if (s.phase_cnt == cfg.stop_line_limit) begin
						{s.motor_one, s.motor_two} = {MOTOR_REL, MOTOR_REL};
						g       = g + GRID_ONE;
						s.phase = PH_IDLE;
						dn      = 1'b1;
					end
				end
				PH_SPIN: begin
					{s.motor_one, s.motor_two} = {MOTOR_FWD, MOTOR_BAK};
					if (!on_br && s.mid_stage == 2'd0) s.mid_stage = 2'd1;
					if (on_br && s.mid_stage == 2'd1) s.mid_stage = 2'd2;
					if (on_bl && s.mid_stage == 2'd2) s.mid_stage = 2'd3;
					if (((!on_br && !on_bl) || (!on_fr && !on_fl)) && s.mid_stage == 2'd3) begin
						{s.motor_one, s.motor_two} = {MOTOR_REL, MOTOR_REL};
						s.phase     = PH_FOLLOW;
						s.mid_stage = 2'd0;
						s.phase_cnt = 8'd0;
					end
				end
				default: begin
				end
			endcase
			if (do_sweep) begin
				watch = (cur.maneuver == MAN_RIGHT) ? on_fl : on_fr;
				if (watch && s.mid_stage == 2'd0) s.mid_stage = 2'd1;
				if (!watch && s.mid_stage == 2'd1) s.sweep_cnt = s.sweep_cnt + 8'd1;
				if (watch && s.mid_stage == 2'd2) begin
					// line found again after the sweep: follow it in
					{s.motor_one, s.motor_two} = {MOTOR_REL, MOTOR_REL};
					s.phase     = PH_FOLLOW;
					s.mid_stage = 2'd0;
					s.phase_cnt = 8'd0;
				end else if (s.sweep_cnt == cfg.turn_sweep_limit) begin
					s.mid_stage = 2'd2;
				end
			end
		end
	end

	assign nxt       = s;
	assign grids_nxt = g;
	assign done      = dn;

endmodule

@@ design/line_follower_grid_navigator.sv @@
// ----------------------------------------------------------------------------
// Line follower grid navigator
// Command beats pass the input register, then the result register.
// Throughput: one beat per cycle unless res.ready stalls; the state loop closes
// through the step logic between the input register and the result register.
// Reset: arst_n clears state, grid count and valids; config takes its defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follower_grid_navigator #(
	parameter int GRID_COUNT_BITS = lfgn_pkg::GRID_COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	lfgn_cmd_if.sink                             cmd,
	lfgn_res_if.source                           res,
	input  logic                                 cfg_wr_en,
	input  logic [lfgn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [7:0]                           cfg_wdata
);
	import lfgn_pkg::*;

	lfgn_cfg_t                  cfg_q;
	lfgn_state_t                state_q;
	logic [GRID_COUNT_BITS-1:0] grids_q;

	lfgn_sample_t smp_s1;
	logic         vld_s1;

	logic [1:0]   motor_one_s2, motor_two_s2;
	logic [7:0]   speed_s2;
	logic         done_s2, busy_s2;
	logic [15:0]  grid_s2;
	logic         vld_s2;

	lfgn_state_t                nxt;
	logic [GRID_COUNT_BITS-1:0] grids_nxt;
	logic                       done;
	logic                       adv;

	// stage 1 moves on whenever the result register is free or draining
	assign adv       = vld_s1 && (!vld_s2 || res.ready);
	assign cmd.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CRUISE_SPEED:   cfg_q.cruise_speed      <= cfg_wdata;
				CFG_MANEUVER_SPEED: cfg_q.maneuver_speed    <= cfg_wdata;
				CFG_SWEEP_LIMIT:    cfg_q.turn_sweep_limit  <= cfg_wdata;
				CFG_CONFIRM_LIMIT:  cfg_q.mid_confirm_limit <= cfg_wdata;
				CFG_TRAVEL_LIMIT:   cfg_q.mid_travel_limit  <= cfg_wdata;
				CFG_STOP_LIMIT:     cfg_q.stop_line_limit   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			smp_s1 <= '{
				command:     cmd.command,
				maneuver:    cmd.maneuver,
				front_right: cmd.front_right,
				front_left:  cmd.front_left,
				back_right:  cmd.back_right,
				back_left:   cmd.back_left
			};
		end
	end

	lfgn_step #(
		.GRID_COUNT_BITS(GRID_COUNT_BITS)
	) u_step (
		.cur       (state_q),
		.grids_cur (grids_q),
		.cfg       (cfg_q),
		.smp       (smp_s1),
		.nxt       (nxt),
		.grids_nxt (grids_nxt),
		.done      (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			grids_q <= '0;
			vld_s2  <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= nxt;
				grids_q <= grids_nxt;
				vld_s2  <= 1'b1;
			end else if (res.ready) begin
				vld_s2  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			motor_one_s2 <= nxt.motor_one;
			motor_two_s2 <= nxt.motor_two;
			speed_s2     <= nxt.speed;
			done_s2      <= done;
			busy_s2      <= (nxt.phase != PH_IDLE);
			grid_s2      <= 16'(grids_nxt);
		end
	end

	assign res.valid            = vld_s2;
	assign res.motor_one_action = motor_one_s2;
	assign res.motor_two_action = motor_two_s2;
	assign res.motor_speed      = speed_s2;
	assign res.maneuver_done    = done_s2;
	assign res.busy_res         = busy_s2;
	assign res.grid_count       = grid_s2;

endmodule

@@ design/lfgn_checker.sv @@
// ----------------------------------------------------------------------------
// Line follower grid navigator checker
// Port-level checks on result beats, bound to the navigator top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "line_follower_grid_navigator_assert.svh"

module lfgn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  motor_one_action,
	input logic [1:0]  motor_two_action,
	input logic [7:0]  motor_speed,
	input logic        maneuver_done,
	input logic        busy_res,
	input logic [15:0] grid_count
);
	import lfgn_pkg::*;

	// a stalled result beat holds
	`LFGN_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(motor_one_action) && $stable(motor_two_action) && $stable(motor_speed) && $stable(maneuver_done) && $stable(busy_res) && $stable(grid_count))

	// a finishing beat leaves the block idle with the motors released
	`LFGN_ASSERT_NOW(a_done_release, clk, arst_n, res_valid && maneuver_done, !busy_res && motor_one_action == MOTOR_REL && motor_two_action == MOTOR_REL)

	// accepted beat followed by ready means the input stage drained into the result
	`LFGN_ASSERT_NEXT(a_accept_to_result, clk, arst_n, (cmd_valid && cmd_ready) ##1 cmd_ready, res_valid)

endmodule

bind line_follower_grid_navigator lfgn_checker u_lfgn_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.motor_one_action (res.motor_one_action),
	.motor_two_action (res.motor_two_action),
	.motor_speed      (res.motor_speed),
	.maneuver_done    (res.maneuver_done),
	.busy_res         (res.busy_res),
	.grid_count       (res.grid_count)
);

@@ tb/tb_line_follower_grid_navigator.sv @@
// ----------------------------------------------------------------------------
// Line follower grid navigator testbench
// Drives command beats through the valid/ready channel and predicts each
// result beat from a local model of the maneuver phases, counters, motor
// commands and grid count. Runs a directed pass, then random maneuver
// sequences under several register settings, with random gaps
// on both channels and one long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_follower_grid_navigator;
	import lfgn_pkg::*;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [1:0]  motor_one;
		logic [1:0]  motor_two;
		logic [7:0]  speed;
		logic        done;
		logic        busy;
		logic [15:0] grids;
	} drive_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [7:0]                cfg_wdata;

	lfgn_cmd_if cmd_bus ();
	lfgn_res_if res_bus ();

	line_follower_grid_navigator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.res       (res_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// navigator model state
	lfgn_state_t   nav_st = STATE_RESET;
	lfgn_cfg_t     nav_cfg = CFG_RESET;
	logic [15:0]   nav_grids = '0;
	bit            on_fr, on_fl, on_br, on_bl;

	drive_result_t expected_drive_q[$];
	int            fail_count = 0;
	bit            gaps_on = 1'b1;
	bit            stalls_on = 1'b1;
	bit            hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 6);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [3:0] sensors(int p_on);
		logic [3:0] s;
		int i;
		for (i = 0; i < 4; i++) s[i] = ($urandom_range(0, 99) < p_on) ? 1'b0 : 1'b1;
		return s;
	endfunction

	function automatic void drive_motors(logic [1:0] a, logic [1:0] b);
		nav_st.motor_one = a;
		nav_st.motor_two = b;
	endfunction

	function automatic bit all_off();
		return !(on_fr || on_fl || on_br || on_bl);
	endfunction

	function automatic void steer(logic [1:0] d);
		if (on_fr && on_br) drive_motors(MOTOR_REL, d);
		else if (on_fl && on_bl) drive_motors(d, MOTOR_REL);
		else if (on_bl) drive_motors(MOTOR_BAK, MOTOR_FWD);
		else if (on_br) drive_motors(MOTOR_FWD, MOTOR_BAK);
		else if (on_fr) drive_motors(MOTOR_BAK, MOTOR_FWD);
		else if (on_fl) drive_motors(MOTOR_FWD, MOTOR_BAK);
	endfunction

	function automatic bit stop_on_grid();
		drive_motors(MOTOR_REL, MOTOR_REL);
		nav_grids = nav_grids + 16'd1;
		nav_st.phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic bit follow_forward(bit turn);
		if (all_off() || (on_bl && on_br)) drive_motors(MOTOR_FWD, MOTOR_FWD);
		else if (on_fr && on_fl && (turn || nav_st.mid_stage == 2'd1)) return stop_on_grid();
		else if (on_fr && on_fl && nav_st.mid_stage == 2'd0) drive_motors(MOTOR_FWD, MOTOR_FWD);
		else steer(MOTOR_FWD);
		if (!on_bl && !on_br) drive_motors(MOTOR_FWD, MOTOR_FWD);
		if (!on_fl && !on_fr) drive_motors(MOTOR_FWD, MOTOR_FWD);
		if (!turn && on_br && on_bl && nav_st.mid_stage == 2'd0) nav_st.mid_stage = 2'd1;
		return 1'b0;
	endfunction

	function automatic bit travel_done();
		if (nav_st.mid_stage == 2'd2 && nav_st.phase_cnt == nav_cfg.mid_travel_limit) begin
			drive_motors(MOTOR_REL, MOTOR_REL);
			nav_st.mid_stage = 2'd3;
			nav_st.phase_cnt = 8'd0;
			nav_st.phase = PH_FINAL;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void follow_reverse(bit around);
		if (all_off() || (on_bl && on_br) || (on_fr && on_fl && nav_st.mid_stage == 2'd0))
			drive_motors(MOTOR_BAK, MOTOR_BAK);
		else steer(MOTOR_BAK);
		if (!on_bl && !on_br) drive_motors(MOTOR_BAK, MOTOR_BAK);
		if (!on_fl && !on_fr) drive_motors(MOTOR_BAK, MOTOR_BAK);
		if (on_br && on_bl && nav_st.mid_stage == 2'd0) begin
			drive_motors(MOTOR_BAK, MOTOR_BAK);
			nav_st.mid_stage = 2'd1;
		end
		if ((!on_fr || !on_fl) && nav_st.mid_stage == 2'd2) nav_st.phase_cnt++;
		// a plain reverse checks travel before the confirm count, turn-around after
		if (!around && travel_done()) return;
		if (on_fr && on_fl && nav_st.mid_stage == 2'd1) begin
			drive_motors(MOTOR_BAK, MOTOR_BAK);
			nav_st.phase_cnt++;
		end
		if (nav_st.mid_stage == 2'd1 && nav_st.phase_cnt == nav_cfg.mid_confirm_limit) begin
			nav_st.mid_stage = 2'd2;
			nav_st.phase_cnt = 8'd0;
		end
		if (around) void'(travel_done());
	endfunction

	function automatic bit final_pass();
		if (all_off() || (on_bl && on_br)) drive_motors(MOTOR_FWD, MOTOR_FWD);
		else if (on_fr && on_fl) nav_st.phase_cnt++;
		else steer(MOTOR_FWD);
		if (!on_bl && !on_br) drive_motors(MOTOR_FWD, MOTOR_FWD);
		if (nav_st.phase_cnt == nav_cfg.stop_line_limit) return stop_on_grid();
		return 1'b0;
	endfunction

	function automatic void sweep_pass();
		bit w;
		w = (nav_st.maneuver == MAN_RIGHT) ? on_fl : on_fr;
		if (w && nav_st.mid_stage == 2'd0) nav_st.mid_stage = 2'd1;
		if (!w && nav_st.mid_stage == 2'd1) nav_st.sweep_cnt++;
		if (w && nav_st.mid_stage == 2'd2) begin
			drive_motors(MOTOR_REL, MOTOR_REL);
			nav_st.phase = PH_FOLLOW;
			nav_st.mid_stage = 2'd0;
			nav_st.phase_cnt = 8'd0;
			return;
		end
		if (nav_st.sweep_cnt == nav_cfg.turn_sweep_limit) nav_st.mid_stage = 2'd2;
	endfunction

	function automatic void spin_pass();
		drive_motors(MOTOR_FWD, MOTOR_BAK);
		if (!on_br && nav_st.mid_stage == 2'd0) nav_st.mid_stage = 2'd1;
		if (on_br && nav_st.mid_stage == 2'd1) nav_st.mid_stage = 2'd2;
		if (on_bl && nav_st.mid_stage == 2'd2) nav_st.mid_stage = 2'd3;
		if (((!on_br && !on_bl) || (!on_fr && !on_fl)) && nav_st.mid_stage == 2'd3) begin
			drive_motors(MOTOR_REL, MOTOR_REL);
			nav_st.phase = PH_FOLLOW;
			nav_st.mid_stage = 2'd0;
			nav_st.phase_cnt = 8'd0;
		end
	endfunction

	// advance the model by one accepted beat and queue the result it causes
	function automatic void advance_navigator(lfgn_sample_t b);
		drive_result_t r;
		bit            done;
		done = 1'b0;
		on_fr = !b.front_right;
		on_fl = !b.front_left;
		on_br = !b.back_right;
		on_bl = !b.back_left;
		if (b.command) begin
			if (b.maneuver <= MAN_AROUND) begin
				nav_st.maneuver = b.maneuver;
				nav_st.speed = (b.maneuver == MAN_FORWARD) ? nav_cfg.cruise_speed
				                                          : nav_cfg.maneuver_speed;
				nav_st.mid_stage = 2'd0;
				nav_st.phase_cnt = 8'd0;
				nav_st.sweep_cnt = 8'd0;
				if (b.maneuver == MAN_FORWARD || b.maneuver == MAN_BACKWARD)
					nav_st.phase = PH_FOLLOW;
				else if (b.maneuver == MAN_AROUND)
					nav_st.phase = PH_SPIN;
				else
					nav_st.phase = PH_BACKOFF;
			end
		end else begin
			case (nav_st.phase)
				PH_BACKOFF: begin
					if ((nav_st.maneuver == MAN_RIGHT) ? on_fr : on_fl) begin
						if (nav_st.maneuver == MAN_RIGHT) nav_st.motor_one = MOTOR_BAK;
						else nav_st.motor_two = MOTOR_BAK;
					end else begin
						// the exit beat also counts as the first sweep pass
						drive_motors(MOTOR_REL, MOTOR_REL);
						if (nav_st.maneuver == MAN_RIGHT) nav_st.motor_two = MOTOR_FWD;
						else nav_st.motor_one = MOTOR_FWD;
						nav_st.phase = PH_SWEEP;
						sweep_pass();
					end
				end
				PH_SWEEP: sweep_pass();
				PH_FOLLOW: begin
					if (nav_st.maneuver == MAN_BACKWARD || nav_st.maneuver == MAN_AROUND)
						follow_reverse(nav_st.maneuver == MAN_AROUND);
					else
						done = follow_forward(nav_st.maneuver != MAN_FORWARD);
				end
				PH_FINAL: done = final_pass();
				PH_SPIN: spin_pass();
				default: ;
			endcase
		end
		r.motor_one = nav_st.motor_one;
		r.motor_two = nav_st.motor_two;
		r.speed     = nav_st.speed;
		r.done      = done;
		r.busy      = (nav_st.phase != PH_IDLE);
		r.grids     = nav_grids;
		expected_drive_q.push_back(r);
	endfunction

	task automatic send_beat(input lfgn_sample_t b);
		int gap;
		gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.command     <= b.command;
		cmd_bus.maneuver    <= b.maneuver;
		cmd_bus.front_right <= b.front_right;
		cmd_bus.front_left  <= b.front_left;
		cmd_bus.back_right  <= b.back_right;
		cmd_bus.back_left   <= b.back_left;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		advance_navigator(b);
	endtask

	// drop valid and wait for every outstanding result plus the pipeline depth
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input lfgn_cfg_t c);
		logic [CFG_INDEX_BITS-1:0] idx [6];
		logic [7:0]                val [6];
		int                        i;
		idx = '{CFG_CRUISE_SPEED, CFG_MANEUVER_SPEED, CFG_SWEEP_LIMIT,
		        CFG_CONFIRM_LIMIT, CFG_TRAVEL_LIMIT, CFG_STOP_LIMIT};
		val = '{c.cruise_speed, c.maneuver_speed, c.turn_sweep_limit,
		        c.mid_confirm_limit, c.mid_travel_limit, c.stop_line_limit};
		for (i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		nav_cfg = c;
	endtask

	function automatic lfgn_cfg_t random_config(int limit_hi);
		lfgn_cfg_t c;
		c.cruise_speed      = 8'($urandom_range(0, 255));
		c.maneuver_speed    = 8'($urandom_range(0, 255));
		c.turn_sweep_limit  = 8'($urandom_range(1, limit_hi));
		c.mid_confirm_limit = 8'($urandom_range(1, limit_hi));
		c.mid_travel_limit  = 8'($urandom_range(1, limit_hi));
		c.stop_line_limit   = 8'($urandom_range(1, limit_hi));
		return c;
	endfunction

	// mostly start beats followed by samples until the maneuver ends or a cap is hit
	task automatic run_maneuvers(input int n_items);
		int         sent, cap, k, p_on;
		logic [2:0] man;
		sent = 0;
		while (sent < n_items) begin
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			p_on      = 25 + 25 * $urandom_range(0, 2);
			if ($urandom_range(0, 7) == 0) begin
				if (nav_st.phase == PH_IDLE && $urandom_range(0, 1))
					send_beat({1'b0, 3'($urandom_range(0, 7)), sensors(50)});
				else
					send_beat({1'b1, 3'($urandom_range(int'(MAN_AROUND) + 1, 7)), sensors(50)});
				sent++;
			end else begin
				man = 3'($urandom_range(0, int'(MAN_AROUND)));
				send_beat({1'b1, man, sensors(50)});
				cap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 250;
				k = 0;
				do begin
					send_beat({1'b0, 3'($urandom_range(0, 7)), sensors(p_on)});
					k++;
				end while (nav_st.phase != PH_IDLE && k < cap && sent + k + 1 < n_items);
				sent += k + 1;
			end
		end
	endtask

	task automatic test_directed();
		int code;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		// samples with nothing running
		send_beat({1'b0, MAN_FORWARD, 4'b0000});
		send_beat({1'b0, MAN_FORWARD, 4'b1111});
		// unknown maneuver codes are ignored
		for (code = int'(MAN_AROUND) + 1; code <= 7; code++)
			send_beat({1'b1, 3'(code), 4'($urandom_range(0, 15))});
		// forward: back pair crosses, then front pair ends it
		send_beat({1'b1, MAN_FORWARD, 4'b1111});
		send_beat({1'b0, MAN_FORWARD, 4'b1100});
		send_beat({1'b0, MAN_FORWARD, 4'b0011});
		// right turn back-off, then exit into the sweep
		send_beat({1'b1, MAN_RIGHT, 4'b1111});
		send_beat({1'b0, MAN_RIGHT, 4'b0111});
		send_beat({1'b0, MAN_RIGHT, 4'b1111});
		// abort the sweep with a left turn
		send_beat({1'b1, MAN_LEFT, 4'b0000});
		send_beat({1'b0, MAN_LEFT, 4'b1011});
		// turn-around spin into reverse follow
		send_beat({1'b1, MAN_AROUND, 4'b1111});
		send_beat({1'b0, MAN_AROUND, 4'b1111});
		send_beat({1'b0, MAN_AROUND, 4'b1100});
		send_beat({1'b0, MAN_AROUND, 4'b0000});
		// backward crossing and first confirm count
		send_beat({1'b1, MAN_BACKWARD, 4'b0000});
		send_beat({1'b0, MAN_BACKWARD, 4'b1100});
		send_beat({1'b0, MAN_BACKWARD, 4'b0011});
		settle();
	endtask

	task automatic test_small_limits();
		apply_config(random_config(6));
		run_maneuvers(125);
		settle();
		apply_config(random_config(6));
		run_maneuvers(125);
		settle();
	endtask

	task automatic test_low_extremes();
		apply_config('{cruise_speed: 8'd0, maneuver_speed: 8'd255, turn_sweep_limit: 8'd1,
		               mid_confirm_limit: 8'd1, mid_travel_limit: 8'd1, stop_line_limit: 8'd1});
		run_maneuvers(150);
		settle();
	endtask

	task automatic test_high_extremes();
		apply_config('{cruise_speed: 8'd255, maneuver_speed: 8'd0, turn_sweep_limit: 8'd255,
		               mid_confirm_limit: 8'd255, mid_travel_limit: 8'd255,
		               stop_line_limit: 8'd255});
		run_maneuvers(150);
		settle();
	endtask

	task automatic test_backpressure();
		int k;
		apply_config(random_config(4));
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		hold_req  = 1'b1;
		send_beat({1'b1, MAN_BACKWARD, 4'b1111});
		for (k = 0; k < 40; k++) send_beat({1'b0, MAN_FORWARD, sensors(50)});
		settle();
	endtask

	task automatic test_mid_limits();
		apply_config(random_config(40));
		run_maneuvers(150);
		settle();
	endtask

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// result checker
	initial begin
		drive_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && res_bus.valid && res_bus.ready) begin
				if (expected_drive_q.size() == 0) begin
					$error("result beat with no expected result");
					fail_count++;
				end else begin
					exp_r = expected_drive_q.pop_front();
					check_field("motor_one_action", exp_r.motor_one, res_bus.motor_one_action);
					check_field("motor_two_action", exp_r.motor_two, res_bus.motor_two_action);
					check_field("motor_speed", exp_r.speed, res_bus.motor_speed);
					check_field("maneuver_done", exp_r.done, res_bus.maneuver_done);
					check_field("busy_res", exp_r.busy, res_bus.busy_res);
					check_field("grid_count", exp_r.grids, res_bus.grid_count);
				end
			end
		end
	end

	// result ready with random stalls and one long hold-off
	initial begin
		int   stall_left;
		logic rdy;
		stall_left = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				rdy = 1'b0;
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 99) < 25) begin
				stall_left = pick_gap() - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			res_bus.ready <= rdy;
		end
	end

	// end the run when no beat moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) quiet = 0;
			else quiet++;
		end
		$display("line_follower_grid_navigator test failed");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= CFG_CRUISE_SPEED;
		cfg_wdata           <= 8'd0;
		cmd_bus.valid       <= 1'b0;
		cmd_bus.command     <= 1'b0;
		cmd_bus.maneuver    <= MAN_FORWARD;
		cmd_bus.front_right <= 1'b1;
		cmd_bus.front_left  <= 1'b1;
		cmd_bus.back_right  <= 1'b1;
		cmd_bus.back_left   <= 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_limits();
		test_low_extremes();
		test_high_extremes();
		test_backpressure();
		test_mid_limits();
		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("line_follower_grid_navigator test passed");
		end else begin
			$display("line_follower_grid_navigator test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/lfgn_pkg.sv
design/lfgn_if.sv
design/lfgn_step.sv
design/line_follower_grid_navigator.sv
design/lfgn_checker.sv
tb/tb_line_follower_grid_navigator.sv
